### hdl/sme_pkg.sv
// ----------------------------------------------------------------------------
// sme_pkg
// Shared types, opcodes and sizes for the stack machine executor.
// ----------------------------------------------------------------------------
package sme_pkg;

  // Sizes
  localparam int STACK_DEPTH   = 128;
  localparam int PROGRAM_DEPTH = 128;
  localparam int SP_W          = $clog2(STACK_DEPTH + 1);
  localparam int PC_W          = $clog2(PROGRAM_DEPTH);
  localparam int DATA_W        = 32;

  // Opcodes
  typedef enum logic [4:0] {
    CMD_QUIT = 5'd0,
    CMD_NOP  = 5'd1,
    CMD_PUSH = 5'd2,
    CMD_DROP = 5'd3,
    CMD_DUP  = 5'd4,
    CMD_OVER = 5'd5,
    CMD_DOT  = 5'd6,
    CMD_EMIT = 5'd7,
    CMD_ADD  = 5'd8,
    CMD_SUB  = 5'd9,
    CMD_MUL  = 5'd10,
    CMD_EQ   = 5'd11,
    CMD_GT   = 5'd12,
    CMD_LT   = 5'd13,
    CMD_NOT  = 5'd14,
    CMD_THEN = 5'd15,
    CMD_GOTO = 5'd16
  } cmd_e;

  // Print kinds
  localparam logic [1:0] PRINT_NONE = 2'd0;
  localparam logic [1:0] PRINT_NUM  = 2'd1;
  localparam logic [1:0] PRINT_CHAR = 2'd2;

  // Fault codes
  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_UNDER = 2'd1;
  localparam logic [1:0] FAULT_OVER  = 2'd2;
  localparam logic [1:0] FAULT_JUMP  = 2'd3;

  // Per-cell load select
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_UP   = 2'd1,
    CELL_DN1  = 2'd2,
    CELL_DN2  = 2'd3
  } cell_mode_t;

  // Control from the decoder to the cell chain
  typedef struct packed {
    cell_mode_t          top_mode;
    cell_mode_t          rest_mode;
    logic [DATA_W-1:0]   top_val;
  } stack_ctl_t;

  // Input beat
  typedef struct packed {
    logic [4:0]         command;
    logic signed [31:0] literal;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic [6:0]         next_pc;
    logic               halted;
    logic [1:0]         print_kind;
    logic signed [31:0] print_value;
    logic [1:0]         fault;
  } out_item_t;

endpackage

### hdl/sme_cell.sv
// ----------------------------------------------------------------------------
// sme_cell
// One stack entry: loads from its upper neighbor, from one or two entries
// below, or holds.
// ----------------------------------------------------------------------------
module sme_cell
  import sme_pkg::*;
(
  input  logic              clk,
  input  cell_mode_t        mode,
  input  logic [DATA_W-1:0] from_up,
  input  logic [DATA_W-1:0] from_dn1,
  input  logic [DATA_W-1:0] from_dn2,
  output logic [DATA_W-1:0] q
);

  logic [DATA_W-1:0] val_r;
  logic [DATA_W-1:0] val_nxt;

  // Pick the new entry value
  always_comb begin
    unique case (mode)
      CELL_UP:  val_nxt = from_up;
      CELL_DN1: val_nxt = from_dn1;
      CELL_DN2: val_nxt = from_dn2;
      default:  val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign q = val_r;

endmodule

### hdl/sme_stack.sv
// ----------------------------------------------------------------------------
// sme_stack
// Data stack as a chain of cells; cell 0 is the top of stack. Push shifts
// the chain down, pops shift it up by one or two.
// ----------------------------------------------------------------------------
module sme_stack
  import sme_pkg::*;
(
  input  logic              clk,
  input  stack_ctl_t        ctl,
  output logic [DATA_W-1:0] tos,
  output logic [DATA_W-1:0] nos
);

  // Two extra tail slots feed the bottom cells on a pop
  logic [DATA_W-1:0] cell_q [STACK_DEPTH+2];

  assign cell_q[STACK_DEPTH]   = '0;
  assign cell_q[STACK_DEPTH+1] = '0;

  // Build the chain
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_top
      sme_cell u_cell (
        .clk      (clk),
        .mode     (ctl.top_mode),
        .from_up  (ctl.top_val),
        .from_dn1 (cell_q[1]),
        .from_dn2 (cell_q[2]),
        .q        (cell_q[0])
      );
    end else begin : g_rest
      sme_cell u_cell (
        .clk      (clk),
        .mode     (ctl.rest_mode),
        .from_up  (cell_q[i-1]),
        .from_dn1 (cell_q[i+1]),
        .from_dn2 (cell_q[i+2]),
        .q        (cell_q[i])
      );
    end
  end

  assign tos = cell_q[0];
  assign nos = cell_q[1];

endmodule

### hdl/stack_machine_executor_unit.sv
// ----------------------------------------------------------------------------
// stack_machine_executor_unit
// Executes one fetched stack-machine instruction per input beat and returns
// the next program counter, printed value, halt and fault in one result beat.
// ----------------------------------------------------------------------------
//   channel | ports                          | beat
//   input   | in_valid, in_stall, in_data    | command, literal
//   result  | out_valid, out_stall, out_data | next_pc, halted, print, fault
//
// Each instruction is decoded and executed in the cycle its beat is taken;
// the result appears on out_data the next cycle. One instruction per cycle
// while in_stall is low; the cell chain shift and the 32x32 multiply fit in it.
// Reset clears the stack pointer, program counter, halt flag and out_valid;
// stack entries are not cleared. The input is stalled only while a result
// waits in the output register and out_stall is high.
// ----------------------------------------------------------------------------
module stack_machine_executor_unit
  import sme_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r, out_data_nxt;
  logic [SP_W-1:0] sp_r, sp_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            halt_r, halt_nxt;

  logic              accept;
  logic [DATA_W-1:0] a, b;
  logic [DATA_W-1:0] prod;
  logic [DATA_W-1:0] lit;
  logic [1:0]        need;
  logic              grows;
  logic [1:0]        flt;
  logic              run;
  logic              jump;
  logic [DATA_W-1:0] target;
  logic [1:0]        kind;
  logic [DATA_W-1:0] pval;
  logic [PC_W:0]     pc_inc;
  logic [PC_W+6:0]   pc_ext;
  stack_ctl_t        ctl;

  // Handshake: output register frees the input side
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  sme_stack u_stack (
    .clk (clk),
    .ctl (ctl),
    .tos (a),
    .nos (b)
  );

  assign prod = a * b;
  assign lit  = in_data.literal;

  // Operand needs and stack growth per opcode
  always_comb begin
    need  = 2'd0;
    grows = 1'b0;
    unique case (in_data.command)
      CMD_DROP, CMD_DOT, CMD_EMIT, CMD_NOT, CMD_GOTO: need = 2'd1;
      CMD_DUP: begin
        need  = 2'd1;
        grows = 1'b1;
      end
      CMD_OVER: begin
        need  = 2'd2;
        grows = 1'b1;
      end
      CMD_PUSH: grows = 1'b1;
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_EQ, CMD_GT, CMD_LT, CMD_THEN: need = 2'd2;
      default: ;
    endcase
  end

  // Fault check, in priority order
  always_comb begin
    if (in_data.command > CMD_GOTO) begin
      flt = FAULT_OVER;
    end else if (sp_r < SP_W'(need)) begin
      flt = FAULT_UNDER;
    end else if (grows && (sp_r >= SP_W'(STACK_DEPTH))) begin
      flt = FAULT_OVER;
    end else if (in_data.command == CMD_GOTO && a[DATA_W-1]) begin
      flt = FAULT_JUMP;
    end else if (in_data.command == CMD_THEN && (b != '0) && a[DATA_W-1]) begin
      flt = FAULT_JUMP;
    end else begin
      flt = FAULT_NONE;
    end
  end

  assign run = accept && !halt_r && (flt == FAULT_NONE) && (in_data.command != CMD_QUIT);

  // Decode the stack move, print and jump
  always_comb begin
    ctl.top_mode  = CELL_HOLD;
    ctl.rest_mode = CELL_HOLD;
    ctl.top_val   = '0;
    sp_nxt        = sp_r;
    kind          = PRINT_NONE;
    pval          = '0;
    jump          = 1'b0;
    target        = a;
    unique case (in_data.command)
      CMD_PUSH, CMD_DUP, CMD_OVER: begin
        ctl.top_mode  = CELL_UP;
        ctl.rest_mode = CELL_UP;
        sp_nxt        = sp_r + SP_W'(1);
        if (in_data.command == CMD_PUSH) begin
          ctl.top_val = lit;
        end else if (in_data.command == CMD_DUP) begin
          ctl.top_val = a;
        end else begin
          ctl.top_val = b;
        end
      end
      CMD_DROP, CMD_DOT, CMD_EMIT, CMD_GOTO: begin
        ctl.top_mode  = CELL_DN1;
        ctl.rest_mode = CELL_DN1;
        sp_nxt        = sp_r - SP_W'(1);
        if (in_data.command == CMD_DOT) begin
          kind = PRINT_NUM;
          pval = a;
        end else if (in_data.command == CMD_EMIT) begin
          kind = PRINT_CHAR;
          pval = {24'd0, a[7:0]};
        end else if (in_data.command == CMD_GOTO) begin
          jump = 1'b1;
        end
      end
      CMD_NOT: begin
        ctl.top_mode = CELL_UP;
        ctl.top_val  = {31'd0, (a == '0)};
      end
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_EQ, CMD_GT, CMD_LT: begin
        ctl.top_mode  = CELL_UP;
        ctl.rest_mode = CELL_DN1;
        sp_nxt        = sp_r - SP_W'(1);
        if (in_data.command == CMD_ADD) begin
          ctl.top_val = a + b;
        end else if (in_data.command == CMD_SUB) begin
          ctl.top_val = a - b;
        end else if (in_data.command == CMD_MUL) begin
          ctl.top_val = prod;
        end else if (in_data.command == CMD_EQ) begin
          ctl.top_val = {31'd0, (a == b)};
        end else if (in_data.command == CMD_GT) begin
          ctl.top_val = {31'd0, ($signed(a) < $signed(b))};
        end else begin
          ctl.top_val = {31'd0, ($signed(b) < $signed(a))};
        end
      end
      CMD_THEN: begin
        ctl.top_mode  = CELL_DN2;
        ctl.rest_mode = CELL_DN2;
        sp_nxt        = sp_r - SP_W'(2);
        jump          = (b != '0);
      end
      default: ;
    endcase
    // Drop the move unless the instruction really executes
    if (!run) begin
      ctl.top_mode  = CELL_HOLD;
      ctl.rest_mode = CELL_HOLD;
      sp_nxt        = sp_r;
      kind          = PRINT_NONE;
      pval          = '0;
      jump          = 1'b0;
    end
  end

  // Program counter and halt
  assign pc_inc = {1'b0, pc_r} + (PC_W+1)'(1);

  always_comb begin
    pc_nxt   = pc_r;
    halt_nxt = halt_r;
    if (accept && !halt_r) begin
      if (!run) begin
        halt_nxt = 1'b1;
      end else if (jump) begin
        if (target >= DATA_W'(PROGRAM_DEPTH)) begin
          halt_nxt = 1'b1;
        end else begin
          pc_nxt = target[PC_W-1:0];
        end
      end else if (pc_inc >= (PC_W+1)'(PROGRAM_DEPTH)) begin
        halt_nxt = 1'b1;
      end else begin
        pc_nxt = pc_inc[PC_W-1:0];
      end
    end
  end

  assign pc_ext = {7'd0, pc_nxt};

  // Result beat and output register
  always_comb begin
    out_data_nxt             = out_data_r;
    out_valid_nxt            = out_valid_r && out_stall;
    if (accept) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.next_pc     = pc_ext[6:0];
      out_data_nxt.halted      = halt_nxt;
      out_data_nxt.print_kind  = kind;
      out_data_nxt.print_value = pval;
      out_data_nxt.fault       = halt_r ? FAULT_NONE : flt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sp_r        <= '0;
      pc_r        <= '0;
      halt_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sp_r        <= sp_nxt;
      pc_r        <= pc_nxt;
      halt_r      <= halt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### tb/sv/stack_machine_executor_checker.sv
// ----------------------------------------------------------------------------
// stack_machine_executor_checker
// Watches both channels of the stack machine executor, runs its own copy of
// the machine on every accepted instruction beat and compares each result
// beat field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module stack_machine_executor_checker
  import sme_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Machine state mirrored from the block
  logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
  int                sp;
  logic [PC_W-1:0]   pc;
  logic              halted;

  out_item_t awaited_results [$];
  int        errors;

  assign fail_count = errors;

  // Execute one instruction on the mirrored state and return its result beat
  function automatic out_item_t execute_instr(in_item_t instr);
    out_item_t         res;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] val;
    logic [DATA_W-1:0] target;
    logic [1:0]        flt;
    logic              jump;
    int                need;
    res    = '0;
    flt    = FAULT_NONE;
    jump   = 1'b0;
    target = '0;
    val    = '0;
    a      = (sp >= 1) ? stack_mem[sp-1] : '0;
    b      = (sp >= 2) ? stack_mem[sp-2] : '0;
    case (instr.command)
      CMD_DROP, CMD_DUP, CMD_DOT, CMD_EMIT, CMD_NOT, CMD_GOTO: need = 1;
      CMD_OVER, CMD_ADD, CMD_SUB, CMD_MUL, CMD_EQ, CMD_GT, CMD_LT,
      CMD_THEN: need = 2;
      default: need = 0;
    endcase

    if (!halted) begin
      // Detect faults before touching the state
      if (instr.command > CMD_GOTO) begin
        flt = FAULT_OVER;
      end else if (sp < need) begin
        flt = FAULT_UNDER;
      end else if ((instr.command == CMD_PUSH || instr.command == CMD_DUP ||
                    instr.command == CMD_OVER) && sp >= STACK_DEPTH) begin
        flt = FAULT_OVER;
      end else if (instr.command == CMD_GOTO && a[DATA_W-1]) begin
        flt = FAULT_JUMP;
      end else if (instr.command == CMD_THEN && b != '0 && a[DATA_W-1]) begin
        flt = FAULT_JUMP;
      end

      if (flt != FAULT_NONE || instr.command == CMD_QUIT) begin
        halted = 1'b1;
      end else begin
        case (instr.command)
          CMD_PUSH: begin
            stack_mem[sp] = instr.literal;
            sp++;
          end
          CMD_DUP: begin
            stack_mem[sp] = a;
            sp++;
          end
          CMD_OVER: begin
            stack_mem[sp] = b;
            sp++;
          end
          CMD_DROP: sp--;
          CMD_DOT: begin
            sp--;
            res.print_kind  = PRINT_NUM;
            res.print_value = a;
          end
          CMD_EMIT: begin
            sp--;
            res.print_kind  = PRINT_CHAR;
            res.print_value = {24'd0, a[7:0]};
          end
          CMD_NOT: stack_mem[sp-1] = (a == '0) ? 32'd1 : 32'd0;
          CMD_THEN: begin
            sp -= 2;
            jump   = (b != '0);
            target = a;
          end
          CMD_GOTO: begin
            sp--;
            jump   = 1'b1;
            target = a;
          end
          CMD_ADD, CMD_SUB, CMD_MUL, CMD_EQ, CMD_GT, CMD_LT: begin
            // Top entry is the first operand
            case (instr.command)
              CMD_ADD: val = a + b;
              CMD_SUB: val = a - b;
              CMD_MUL: val = a * b;
              CMD_EQ:  val = (a == b) ? 32'd1 : 32'd0;
              CMD_GT:  val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
              default: val = ($signed(b) < $signed(a)) ? 32'd1 : 32'd0;
            endcase
            stack_mem[sp-2] = val;
            sp--;
          end
          default: ;
        endcase

        // Advance or redirect the program counter; hold it when leaving the program
        if (jump) begin
          if (target >= PROGRAM_DEPTH) halted = 1'b1;
          else pc = target[PC_W-1:0];
        end else if (int'(pc) + 1 >= PROGRAM_DEPTH) begin
          halted = 1'b1;
        end else begin
          pc = pc + 1'b1;
        end
      end
    end

    res.next_pc = pc;
    res.halted  = halted;
    res.fault   = flt;
    return res;
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected 0x%08h, got 0x%08h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Check result beats first, then predict for the instruction taken this edge
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      sp     = 0;
      pc     = '0;
      halted = 1'b0;
      awaited_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result beat with nothing expected: expected none, got 0x%h",
                   $time, out_data);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          compare_field("next_pc", 32'(want.next_pc), 32'(out_data.next_pc));
          compare_field("halted", 32'(want.halted), 32'(out_data.halted));
          compare_field("print_kind", 32'(want.print_kind), 32'(out_data.print_kind));
          compare_field("print_value", want.print_value, out_data.print_value);
          compare_field("fault", 32'(want.fault), 32'(out_data.fault));
        end
      end
      // Queue the prediction behind the older ones
      if (in_valid && !in_stall) begin
        awaited_results.insert(awaited_results.size(), execute_instr(in_data));
      end
    end
    pending <= awaited_results.size();
  end

endmodule

### tb/sv/stack_machine_executor_unit_tb.sv
// ----------------------------------------------------------------------------
// stack_machine_executor_unit_tb
// Drives instruction beats into the stack machine executor: a directed run
// over every opcode but QUIT and every value extreme, random programs that keep the machine
// alive under several idle and stall mixes, and a final halting scenario
// followed by beats the halted block must ignore. The checker does the rest.
// ----------------------------------------------------------------------------
module stack_machine_executor_unit_tb;
  import sme_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 4;
  localparam int RANDOM_ITEMS   = 1900;
  localparam int HOLD_CYCLES    = 60;
  localparam int WATCHDOG_LIMIT = 5000;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  int        fail_count;
  int        pending;

  // Stimulus bookkeeping: exact stack depth and an upper bound on the pc
  int          depth         = 0;
  int          pc_hi         = 0;
  logic [31:0] last_push     = '0;
  bit          grow          = 1'b1;
  int          sent          = 0;
  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  logic        hold_req      = 1'b0;
  logic        hold_seen     = 1'b0;
  int          hold_left     = 0;
  int          quiet_cycles  = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  stack_machine_executor_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  stack_machine_executor_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Stall the result channel: long hold-off on request, otherwise random
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Abort when no beat moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'hFFFF_FFFF;
      3: return 32'h7FFF_FFFF;
      4: return 32'h8000_0000;
      5: return 32'($urandom_range(255));
      default: return $urandom();
    endcase
  endfunction

  // Send one instruction beat and track its effect on depth and pc
  task automatic issue(input logic [4:0] cmd, input logic [31:0] lit);
    in_item_t beat;
    beat.command = cmd;
    beat.literal = lit;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    sent++;
    case (cmd)
      CMD_PUSH: begin
        depth++;
        pc_hi++;
        last_push = lit;
      end
      CMD_DUP, CMD_OVER: begin
        depth++;
        pc_hi++;
      end
      CMD_NOP, CMD_NOT: pc_hi++;
      CMD_THEN: begin
        depth -= 2;
        pc_hi = (last_push < PROGRAM_DEPTH && int'(last_push) > pc_hi + 1) ?
                int'(last_push) : pc_hi + 1;
      end
      CMD_GOTO: begin
        depth--;
        pc_hi = int'(last_push[PC_W-1:0]);
      end
      CMD_QUIT: ;
      default: begin
        depth--;
        pc_hi++;
      end
    endcase
  endtask

  // Jump back to a low address before the program end can be reached
  task automatic rewind_pc();
    if (pc_hi >= 118) begin
      if (depth == STACK_DEPTH) issue(CMD_DROP, rand_word());
      issue(CMD_PUSH, $urandom_range(60));
      issue(CMD_GOTO, rand_word());
    end
  endtask

  // One random instruction or short well-formed sequence that never halts
  task automatic random_step();
    logic [4:0] op;
    int         need;
    int         pick;
    rewind_pc();
    if (depth == STACK_DEPTH) grow = 1'b0;
    else if (depth == 0) grow = 1'b1;
    pick = $urandom_range(99);
    if (pick < (grow ? 55 : 5)) begin
      op = (depth < STACK_DEPTH) ? CMD_PUSH : CMD_DROP;
    end else if (pick < 60) begin
      op   = 5'($urandom_range(CMD_DROP, CMD_NOT));
      need = (op inside {CMD_DROP, CMD_DUP, CMD_DOT, CMD_EMIT, CMD_NOT}) ? 1 : 2;
      if (depth < need || ((op == CMD_DUP || op == CMD_OVER) && depth >= STACK_DEPTH))
        op = (depth < STACK_DEPTH) ? CMD_PUSH : CMD_DROP;
    end else if (pick < 66) begin
      op = CMD_NOP;
    end else if (pick < 74 && depth < STACK_DEPTH) begin
      issue(CMD_PUSH, $urandom_range(119));
      op = CMD_GOTO;
    end else if (pick < 84 && depth >= 1 && depth < STACK_DEPTH) begin
      // condition comes from whatever is on the stack
      issue(CMD_PUSH, $urandom_range(119));
      op = CMD_THEN;
    end else if (pick < 90 && depth <= STACK_DEPTH - 2) begin
      // false condition: any target, including negative or past the program
      issue(CMD_PUSH, 32'd0);
      issue(CMD_PUSH, rand_word());
      op = CMD_THEN;
    end else if (depth > 0) begin
      case ($urandom_range(2))
        0: op = CMD_DROP;
        1: op = CMD_DOT;
        default: op = CMD_EMIT;
      endcase
    end else begin
      op = CMD_PUSH;
    end
    issue(op, rand_word());
  endtask

  // Drop valid and wait until every predicted result has been taken
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Stop the machine by one randomly chosen cause
  task automatic halt_machine();
    while (depth > STACK_DEPTH - 2) issue(CMD_DROP, rand_word());
    rewind_pc();
    case ($urandom_range(7))
      0: issue(CMD_QUIT, rand_word());
      1: issue(5'($urandom_range(31, 17)), rand_word());
      2: begin
        // stack underflow
        while (depth > 0) begin
          rewind_pc();
          issue(CMD_DROP, rand_word());
        end
        rewind_pc();
        issue(5'($urandom_range(CMD_GOTO, CMD_DROP)), rand_word());
      end
      3: begin
        // stack overflow
        while (depth < STACK_DEPTH) begin
          rewind_pc();
          issue(CMD_PUSH, rand_word());
        end
        case ($urandom_range(2))
          0: issue(CMD_PUSH, rand_word());
          1: issue(CMD_DUP, rand_word());
          default: issue(CMD_OVER, rand_word());
        endcase
      end
      4: begin
        // negative goto target
        issue(CMD_PUSH, $urandom() | 32'h8000_0000);
        issue(CMD_GOTO, rand_word());
      end
      5: begin
        // taken branch to a negative target
        issue(CMD_PUSH, rand_word() | 32'h1);
        issue(CMD_PUSH, $urandom() | 32'h8000_0000);
        issue(CMD_THEN, rand_word());
      end
      6: begin
        // jump past the program
        issue(CMD_PUSH, 32'(PROGRAM_DEPTH) + $urandom_range(4096));
        issue(CMD_GOTO, rand_word());
      end
      default: begin
        // run off the program end
        issue(CMD_PUSH, 32'(PROGRAM_DEPTH - 2));
        issue(CMD_GOTO, rand_word());
        issue(CMD_NOP, rand_word());
        issue(CMD_NOP, rand_word());
      end
    endcase
  endtask

  initial begin : stimulus
    int phase_end;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: value extremes, every operation but quit, branch corner cases
    issue(CMD_PUSH, 32'h7FFF_FFFF);
    issue(CMD_PUSH, 32'h0000_0001);
    issue(CMD_ADD,  32'hFFFF_FFFF);
    issue(CMD_DUP,  32'h0);
    issue(CMD_MUL,  32'h0);
    issue(CMD_PUSH, 32'h8000_0000);
    issue(CMD_PUSH, 32'hFFFF_FFFF);
    issue(CMD_SUB,  32'h0);
    issue(CMD_OVER, 32'h0);
    issue(CMD_GT,   32'h0);
    issue(CMD_PUSH, 32'h8000_0000);
    issue(CMD_LT,   32'h0);
    issue(CMD_EQ,   32'h0);
    issue(CMD_NOT,  32'h0);
    issue(CMD_NOT,  32'h0);
    issue(CMD_PUSH, 32'h1234_5641);
    issue(CMD_EMIT, 32'h0);
    issue(CMD_DOT,  32'h0);
    issue(CMD_PUSH, 32'h0);
    issue(CMD_PUSH, 32'hFFFF_FFFF);
    issue(CMD_THEN, 32'h0);
    issue(CMD_PUSH, 32'h0);
    issue(CMD_PUSH, 32'd500);
    issue(CMD_THEN, 32'h0);
    issue(CMD_PUSH, 32'd7);
    issue(CMD_PUSH, 32'd3);
    issue(CMD_THEN, 32'h0);
    issue(CMD_PUSH, 32'd10);
    issue(CMD_GOTO, 32'h0);
    issue(CMD_NOP,  32'h0);
    issue(CMD_PUSH, 32'd5);
    issue(CMD_DROP, 32'h0);
    drain();

    // Random programs under four idle and stall mixes
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
          hold_req     <= ~hold_req;
        end
        1: begin
          send_idle_pct = 48;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 48;
        end
        default: begin
          send_idle_pct = 13;
          stall_pct     = 13;
        end
      endcase
      phase_end = sent + RANDOM_ITEMS / 4;
      while (sent < phase_end) random_step();
      drain();
    end

    // Halt the machine, then show that further beats are ignored
    send_idle_pct = 13;
    stall_pct     = 13;
    halt_machine();
    repeat (8) issue(5'($urandom_range(31)), rand_word());

    drain();
    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### files.f
hdl/sme_pkg.sv
hdl/sme_cell.sv
hdl/sme_stack.sv
hdl/stack_machine_executor_unit.sv
tb/sv/stack_machine_executor_checker.sv
tb/sv/stack_machine_executor_unit_tb.sv
